FILE: rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared constants, codes and types of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int CAPACITY    = 64;
  localparam int TIME_BITS   = 48;
  localparam int ID_BITS     = 32;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Request kinds.
  localparam logic [1:0] REQ_SCHEDULE = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_PROCEED  = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // One stored event.
  typedef struct packed {
    logic [TIME_BITS-1:0] ev_time;
    logic [7:0]           token;
    logic [31:0]          arg;
    logic [ID_BITS-1:0]   id;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [1:0]           req_type;
    logic [TIME_BITS-1:0] when_time;
    logic [7:0]           handler_token;
    logic [31:0]          handler_arg;
    logic [ID_BITS-1:0]   cancel_id;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ID_BITS-1:0]   new_id;
    logic [TIME_BITS-1:0] now_out;
    logic [7:0]           fired_token;
    logic [31:0]          fired_arg;
    logic [ID_BITS-1:0]   fired_id;
    logic                 fired_valid;
    logic                 last;
    logic                 is_empty;
  } rsp_t;

  // Result handoff from the sequencer to the output register.
  typedef struct packed {
    logic load;
    rsp_t word;
  } rsp_push_t;

endpackage

FILE: rtl/teq_chan_if.sv
// ----------------------------------------------------------------------------
// teq_req_if / teq_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface teq_req_if import teq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [TIME_BITS-1:0] when_time;
  logic [7:0]           handler_token;
  logic [31:0]          handler_arg;
  logic [ID_BITS-1:0]   cancel_id;

  modport source (output valid, req_type, when_time, handler_token, handler_arg,
                  cancel_id, input ready);
  modport sink (input valid, req_type, when_time, handler_token, handler_arg,
                cancel_id, output ready);
endinterface

interface teq_rsp_if import teq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ID_BITS-1:0]   new_id;
  logic [TIME_BITS-1:0] now_out;
  logic [7:0]           fired_token;
  logic [31:0]          fired_arg;
  logic [ID_BITS-1:0]   fired_id;
  logic                 fired_valid;
  logic                 last;
  logic                 is_empty;

  modport source (output valid, status, new_id, now_out, fired_token, fired_arg,
                  fired_id, fired_valid, last, is_empty, input ready);
  modport sink (input valid, status, new_id, now_out, fired_token, fired_arg,
                fired_id, fired_valid, last, is_empty, output ready);
endinterface

FILE: rtl/teq_ram.sv
// ----------------------------------------------------------------------------
// teq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/teq_ctrl.sv
// ----------------------------------------------------------------------------
// teq_ctrl
// Request sequencer: keeps the event RAM sorted by shifting entries one per
// step, scans it for cancel ids and emits runs of equal-time events.
// ----------------------------------------------------------------------------
module teq_ctrl import teq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_t      req,
  input  logic      can_load,
  output rsp_push_t push,
  output logic      ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output slot_t     ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  slot_t     ram_rdata
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCH_RD  = 4'd1;
  localparam logic [3:0] S_SCH_CMP = 4'd2;
  localparam logic [3:0] S_CAN_RD  = 4'd3;
  localparam logic [3:0] S_CAN_CMP = 4'd4;
  localparam logic [3:0] S_SH_RD   = 4'd5;
  localparam logic [3:0] S_SH_WR   = 4'd6;
  localparam logic [3:0] S_PR_RD   = 4'd7;
  localparam logic [3:0] S_PR_CMP  = 4'd8;
  localparam logic [3:0] S_EM_RD   = 4'd9;
  localparam logic [3:0] S_EM_OUT  = 4'd10;
  localparam logic [3:0] S_RESP    = 4'd11;

  logic [3:0]           state_r, state_nxt;
  req_t                 req_r, req_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic [ID_BITS-1:0]   idc_r, idc_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [ID_BITS-1:0]   nid_r, nid_nxt;
  logic [CNT_W:0]       sh_src;
  slot_t                new_slot;
  logic                 lim_hit;

  assign req_ready = (state_r == S_IDLE);
  assign sh_src    = {1'b0, i_r} + {1'b0, n_r};
  assign lim_hit   = (32'(i_r) >= MAX_RESULTS);

  assign new_slot.ev_time = req_r.when_time;
  assign new_slot.token   = req_r.handler_token;
  assign new_slot.arg     = req_r.handler_arg;
  assign new_slot.id      = idc_r;

  // Next-state and datapath control.
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    now_nxt   = now_r;
    t_nxt     = t_r;
    idc_nxt   = idc_r;
    st_nxt    = st_r;
    nid_nxt   = nid_r;
    ram_we    = 1'b0;
    ram_waddr = i_r[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = i_r[IDX_W-1:0];
    push      = '0;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt = req;
          st_nxt  = ST_OK;
          nid_nxt = '0;
          i_nxt   = '0;
          n_nxt   = '0;
          case (req.req_type)
            REQ_SCHEDULE: begin
              if (32'(cnt_r) >= CAPACITY) begin
                st_nxt    = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                i_nxt     = cnt_r;
                state_nxt = S_SCH_RD;
              end
            end
            REQ_CANCEL: state_nxt = S_CAN_RD;
            REQ_PROCEED: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_PR_RD;
              end
            end
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      // Walk down from the top, moving later events up one place.
      S_SCH_RD: begin
        if (i_r == '0) begin
          ram_we    = 1'b1;
          ram_wdata = new_slot;
          cnt_nxt   = cnt_r + 1'b1;
          nid_nxt   = idc_r;
          idc_nxt   = idc_r + 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = IDX_W'(i_r - 1'b1);
          state_nxt = S_SCH_CMP;
        end
      end
      S_SCH_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.ev_time > req_r.when_time) begin
          i_nxt     = i_r - 1'b1;
          state_nxt = S_SCH_RD;
        end else begin
          ram_wdata = new_slot;
          cnt_nxt   = cnt_r + 1'b1;
          nid_nxt   = idc_r;
          idc_nxt   = idc_r + 1'b1;
          state_nxt = S_RESP;
        end
      end
      // Search for the first event with the given id.
      S_CAN_RD: begin
        if (i_r == cnt_r) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_CAN_CMP;
        end
      end
      S_CAN_CMP: begin
        if (ram_rdata.id == req_r.cancel_id) begin
          n_nxt     = CNT_W'(1);
          state_nxt = S_SH_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_CAN_RD;
        end
      end
      // Close a gap of n_r entries starting at i_r.
      S_SH_RD: begin
        if (sh_src >= {1'b0, cnt_r}) begin
          cnt_nxt   = cnt_r - n_r;
          state_nxt = (req_r.req_type == REQ_CANCEL) ? S_RESP : S_IDLE;
        end else begin
          ram_raddr = sh_src[IDX_W-1:0];
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SH_RD;
      end
      // Count the leading run of equal times.
      S_PR_RD: begin
        if (i_r == cnt_r || lim_hit) begin
          n_nxt     = i_r;
          i_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_PR_CMP;
        end
      end
      S_PR_CMP: begin
        if (i_r == '0) begin
          t_nxt     = ram_rdata.ev_time;
          if (ram_rdata.ev_time > now_r) begin
            now_nxt = ram_rdata.ev_time;
          end
          i_nxt     = CNT_W'(1);
          state_nxt = S_PR_RD;
        end else if (ram_rdata.ev_time == t_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PR_RD;
        end else begin
          n_nxt     = i_r;
          i_nxt     = '0;
          state_nxt = S_EM_RD;
        end
      end
      // Emit the run, one word per event.
      S_EM_RD: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (can_load) begin
          push.load             = 1'b1;
          push.word.status      = ST_OK;
          push.word.now_out     = now_r;
          push.word.fired_token = ram_rdata.token;
          push.word.fired_arg   = ram_rdata.arg;
          push.word.fired_id    = ram_rdata.id;
          push.word.fired_valid = 1'b1;
          push.word.last        = ((i_r + 1'b1) == n_r);
          push.word.is_empty    = (cnt_r == n_r);
          if ((i_r + 1'b1) == n_r) begin
            i_nxt     = '0;
            state_nxt = S_SH_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_EM_RD;
          end
        end
      end
      S_RESP: begin
        if (can_load) begin
          push.load          = 1'b1;
          push.word.status   = st_r;
          push.word.new_id   = nid_r;
          push.word.now_out  = now_r;
          push.word.last     = 1'b1;
          push.word.is_empty = (cnt_r == '0);
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      now_r   <= '0;
      idc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      now_r   <= now_nxt;
      idc_r   <= idc_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    i_r   <= i_nxt;
    n_r   <= n_nxt;
    t_r   <= t_nxt;
    st_r  <= st_nxt;
    nid_r <= nid_nxt;
  end

endmodule

FILE: rtl/timed_event_queue_with_cancel.sv
// ----------------------------------------------------------------------------
// timed_event_queue_with_cancel
// Time-ordered event store with schedule, cancel, proceed and clear requests.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_req and results leave on out_rsp, both
// valid/ready channels. Schedule, cancel and clear give one word with last set;
// proceed gives one word per emitted event (last on the final one), or one
// empty-status word. Events live in one RAM kept sorted by firing time.
// Steps of each request (the RAM has a single read port):
//   schedule: moves each stored event later than the new one up a place.
//   cancel:   searches for the id, then moves later events down a place.
//   proceed:  counts the run, emits one word per run event, closes the gap.
//   clear:    resets the event count.
// A new request is taken only once the previous one has finished, but a result
// word may still wait in the output register meanwhile. When the receiver
// stalls, the sequencer holds before loading its next word.
// Reset clears the event count, current time and id counter at once; no
// clearing pass over the RAM is needed.
// ----------------------------------------------------------------------------
module timed_event_queue_with_cancel import teq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  teq_req_if.sink  in_req,
  teq_rsp_if.source out_rsp
);

  req_t            req;
  rsp_push_t       push;
  logic            can_load;
  logic            out_valid_r;
  rsp_t            out_word_r;
  logic            ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  slot_t           ram_wdata;
  slot_t           ram_rdata;
  logic [SLOT_W-1:0] ram_rbits;

  assign req.req_type      = in_req.req_type;
  assign req.when_time     = in_req.when_time;
  assign req.handler_token = in_req.handler_token;
  assign req.handler_arg   = in_req.handler_arg;
  assign req.cancel_id     = in_req.cancel_id;

  assign can_load  = !out_valid_r || out_rsp.ready;
  assign ram_rdata = slot_t'(ram_rbits);

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .req       (req),
    .can_load  (can_load),
    .push      (push),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  teq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  // Output register: holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.load) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.load) begin
      out_word_r <= push.word;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_word_r.status;
  assign out_rsp.new_id      = out_word_r.new_id;
  assign out_rsp.now_out     = out_word_r.now_out;
  assign out_rsp.fired_token = out_word_r.fired_token;
  assign out_rsp.fired_arg   = out_word_r.fired_arg;
  assign out_rsp.fired_id    = out_word_r.fired_id;
  assign out_rsp.fired_valid = out_word_r.fired_valid;
  assign out_rsp.last        = out_word_r.last;
  assign out_rsp.is_empty    = out_word_r.is_empty;

`ifndef NO_ASSERTIONS
  // A word is never loaded over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push.load |-> can_load) else $error("result word overwritten");

  // Only emitted events may be followed by more words of the same request.
  a_mid_run_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.last) |-> out_word_r.fired_valid)
    else $error("non-final word without an event");

  // An empty-queue answer always reports an empty store.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == ST_EMPTY) |-> out_word_r.is_empty)
    else $error("empty status with stored events");
`endif

endmodule
